FILE: src/double_to_float_saturating_defines.svh
// Assertion macros shared by the conversion block.
`ifndef DOUBLE_TO_FLOAT_SATURATING_DEFINES_SVH
`define DOUBLE_TO_FLOAT_SATURATING_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define D2F_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define D2F_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

FILE: src/d2f_pkg.sv
// Shared constants, types and conversion function for the fp64 to fp32 block.
package d2f_pkg;
   localparam int unsigned DBL_W = 64;
   localparam int unsigned SGL_W = 32;
   localparam int unsigned STAT_W = 3;

   typedef enum logic [STAT_W-1:0] {
      ST_OK   = 3'd0,
      ST_NAN  = 3'd1,
      ST_MAX  = 3'd2,
      ST_ZERO = 3'd3,
      ST_MIN  = 3'd4
   } status_type;

   typedef struct packed {
      logic [SGL_W-1:0] single_bits;
      status_type       conversion_status;
   } result_type;

   localparam logic [62:0] D_INF_MAG    = 63'h7FF0000000000000;
   localparam logic [62:0] D_FLTMAX_MAG = 63'h47EFFFFFE0000000;
   localparam logic [62:0] D_FLTMIN_MAG = 63'h3810000000000000;
   localparam logic [62:0] D_HALFSUB    = 63'h3690000000000000;
   localparam logic [30:0] S_FLTMAX     = 31'h7F7FFFFF;
   localparam logic [30:0] S_FLTMIN     = 31'h00800000;
   localparam logic [10:0] EXP_REBIAS   = 11'd896;

   // Full conversion of one binary64 word.
   function automatic result_type convert(input logic [DBL_W-1:0] x);
      logic [62:0] mag;
      logic        sgn;
      logic [10:0] e;
      logic [30:0] f;
      logic [28:0] rem;
      logic        up;
      result_type  r;
      mag = x[62:0];
      sgn = x[63];
      e   = mag[62:52];
      rem = mag[28:0];
      f   = {8'(e - EXP_REBIAS), mag[51:29]};
      up  = (rem > 29'h10000000) || ((rem == 29'h10000000) && f[0]);
      if (mag > D_INF_MAG) begin
         r.single_bits = {1'b1, S_FLTMAX};
         r.conversion_status = ST_NAN;
      end else if (mag > D_FLTMAX_MAG) begin
         r.single_bits = {sgn, S_FLTMAX};
         r.conversion_status = ST_MAX;
      end else if (mag <= D_HALFSUB) begin
         r.single_bits = '0;
         r.conversion_status = ST_ZERO;
      end else if (mag < D_FLTMIN_MAG) begin
         r.single_bits = {sgn, S_FLTMIN};
         r.conversion_status = ST_MIN;
      end else begin
         r.single_bits = {sgn, f + {30'd0, up}};
         r.conversion_status = ST_OK;
      end
      return r;
   endfunction
endpackage

FILE: src/d2f_req_if.sv
// Input channel carrying one binary64 word.
interface d2f_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] double_bits;
   modport source (output valid, output double_bits, input ready);
   modport sink (input valid, input double_bits, output ready);
endinterface

FILE: src/d2f_rsp_if.sv
// Result channel carrying one binary32 word and its status.
interface d2f_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] single_bits;
   logic [2:0]  conversion_status;
   modport source (output valid, output single_bits, output conversion_status, input ready);
   modport sink (input valid, input single_bits, input conversion_status, output ready);
endinterface

FILE: src/double_to_float_saturating.sv
// Top level: binary64 to saturating binary32 converter.
// Usage:
//   req: valid/ready channel with one binary64 word (double_bits).
//   rsp: valid/ready channel with single_bits and conversion_status.
//   Each word is registered at the input, converted by the combinational
//   logic between the input register and the result register, and shown on
//   rsp from the result register once it has moved there.
//   Throughput: one word per cycle while rsp does not stall; a two-stage
//   pipeline whose stages advance whenever the next stage is empty or
//   being emptied. When rsp stalls, the result register holds and the
//   input register fills; req.ready then drops until the result is taken.
//   Reset (synchronous, active high) empties both stages; no
//   words are lost once accepted. Results are never NaN, infinite or
//   subnormal; status tells which replacement rule applied.
module double_to_float_saturating (
   input logic clock,
   input logic reset,
   d2f_req_if.sink req,
   d2f_rsp_if.source rsp
);
   import d2f_pkg::*;
   `include "double_to_float_saturating_defines.svh"

   logic             in_vld_ff, in_vld_in;
   logic [DBL_W-1:0] in_word_ff;
   logic             out_vld_ff, out_vld_in;
   result_type       out_ff;
   logic             out_adv, in_adv;

   // stage handshakes
   assign out_adv   = !out_vld_ff || rsp.ready;
   assign in_adv    = !in_vld_ff || out_adv;
   assign req.ready = in_adv;
   assign in_vld_in  = in_adv ? req.valid : in_vld_ff;
   assign out_vld_in = out_adv ? in_vld_ff : out_vld_ff;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (in_adv && req.valid) in_word_ff <= req.double_bits;
      if (out_adv && in_vld_ff) out_ff <= convert(in_word_ff);
   end

   assign rsp.valid             = out_vld_ff;
   assign rsp.single_bits       = out_ff.single_bits;
   assign rsp.conversion_status = out_ff.conversion_status;

   `D2F_ASSERT_NEXT(a_hold, clock, reset, out_vld_ff && !rsp.ready, out_vld_ff && $stable(out_ff), "stalled result changed")
   `D2F_ASSERT_NEXT(a_move, clock, reset, in_vld_ff && out_adv, out_vld_ff, "input word lost")
   `D2F_ASSERT_IMP(a_nonan, clock, reset, out_vld_ff, out_ff.single_bits[30:23] != 8'hFF, "result not finite")
   `D2F_ASSERT_IMP(a_zero, clock, reset, out_vld_ff && out_ff.conversion_status == ST_ZERO, out_ff.single_bits == 32'd0, "flush not plus zero")
endmodule
